### hw/rtl/tmbc_pkg.sv
// Package for the tile map box collision block.
// Holds field widths, configuration register codes, operation codes and defaults.
// No dependencies.
`default_nettype none
package tmbc_pkg;

	// Fixed field widths.
	localparam int COORD_W = 25;
	localparam int SIZE_W = 16;
	localparam int TIDX_W = 12;
	localparam int COUNT_W = 7;
	localparam int PIX_W = 9;

	// Doubled-precision coordinates and the divider magnitude.
	localparam int DBL_W = COORD_W + 2;
	localparam int MAG_W = DBL_W - 1;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = PIX_W;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_PIXELS = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [COUNT_W-1:0] RST_COLUMNS = 7'd64;
	localparam logic [COUNT_W-1:0] RST_ROWS = 7'd64;
	localparam logic [PIX_W-1:0] RST_TILE_PIXELS = 9'd16;

	// Operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Divisor that gives the positive-side back-off of one hundredth of a tile.
	localparam int BACKOFF_DIV = 100;

	// Parameter defaults.
	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_FRACTION_BITS = 8;

endpackage
`default_nettype wire

### hw/rtl/tile_map_box_collision_top.sv
// Top level of the tile map box collision block: sequencer, tile map and result register.
// Depends on tmbc_pkg, tmbc_div and tmbc_ram.
//
// After reset the block clears all MAX_COLUMNS*MAX_ROWS tile map entries to blocked
// and takes no item meanwhile; configuration writes are taken at any time.
// A tile write gives no result. A query runs up to eight divisions on one shared
// divider and up to two map reads per axis; an axis that stands still skips its
// divisions and reads, and a query whose start and goal are equal skips both axes.
// The back-off of one hundredth of a tile comes from a constant reciprocal
// multiplication. One query is worked on at a time; a finished result waits in the
// output register while the next item is taken.
`default_nettype none
module tile_map_box_collision_top import tmbc_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      operation,
	input  wire logic [TIDX_W-1:0]         tile_index,
	input  wire logic                      tile_open,
	input  wire logic signed [COORD_W-1:0] start_x,
	input  wire logic signed [COORD_W-1:0] start_y,
	input  wire logic signed [COORD_W-1:0] goal_x,
	input  wire logic signed [COORD_W-1:0] goal_y,
	input  wire logic [SIZE_W-1:0]         box_width,
	input  wire logic [SIZE_W-1:0]         box_height,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [COORD_W-1:0]      new_x,
	output logic signed [COORD_W-1:0]      new_y,
	output logic                           hit_x,
	output logic                           hit_y
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IXW = (AW > 2 * COUNT_W) ? AW : 2 * COUNT_W;
	localparam int TXW = (AW > TIDX_W) ? AW : TIDX_W;
	localparam int UW = PIX_W + FRACTION_BITS;
	localparam int DVS_W = UW + 1;
	localparam int PW = DBL_W + 1 + UW + 1;
	localparam int FW = PW + 2;
	localparam logic signed [FW-1:0] SAT_HI = FW'((2 ** (COORD_W - 1)) - 1);
	localparam logic signed [FW-1:0] SAT_LO = -SAT_HI - FW'(1);

	// Reciprocal of the back-off divisor, exact for every tile size in use.
	localparam int BO_SH = UW + 7;
	localparam longint BO_MUL = ((longint'(1) <<< BO_SH) + BACKOFF_DIV - 1) / BACKOFF_DIV;
	localparam int BOW = UW + BO_SH - 5;

	// Sequencer states.
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_ISSUE = 4'd2;
	localparam logic [3:0] ST_DIV = 4'd3;
	localparam logic [3:0] ST_NEXT = 4'd4;
	localparam logic [3:0] ST_RD_A = 4'd5;
	localparam logic [3:0] ST_CK_A = 4'd6;
	localparam logic [3:0] ST_RD_B = 4'd7;
	localparam logic [3:0] ST_CK_B = 4'd8;
	localparam logic [3:0] ST_MUL = 4'd9;
	localparam logic [3:0] ST_FIX = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	// Division steps of one axis.
	localparam logic [2:0] STEP_TILE = 3'd1;
	localparam logic [2:0] STEP_LEAD = 3'd2;
	localparam logic [2:0] STEP_PA = 3'd3;
	localparam logic [2:0] STEP_PB = 3'd4;

	logic [3:0]  state_q;
	logic [2:0]  step_q;
	logic        axis_q;
	logic [AW:0] clr_q;

	logic [COUNT_W-1:0] columns_q;
	logic [COUNT_W-1:0] rows_q;
	logic [PIX_W-1:0]   pixels_q;

	logic signed [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q;
	logic [SIZE_W-1:0]         bw_q, bh_q;

	logic signed [DBL_W-1:0] t_q, ql_q, qa_q, qb_q;
	logic [UW-1:0]           ud_q;
	logic signed [PW-1:0]    prod_q;

	logic signed [COORD_W-1:0] nx_q, ny_q;
	logic                      hx_q, hy_q;
	logic                      ov_q;

	// Effective configuration values.
	logic [PIX_W-1:0]   pix_eff;
	logic [UW-1:0]      unit;
	logic [DVS_W-1:0]   unit2;
	logic [COUNT_W-1:0] cols_eff;
	logic [COUNT_W-1:0] rows_eff;
	logic [BOW-1:0]     bo_prod;

	assign pix_eff = (pixels_q == '0) ? PIX_W'(1) : pixels_q;
	assign unit = UW'(pix_eff) << FRACTION_BITS;
	assign unit2 = DVS_W'(unit) << 1;
	assign cols_eff = (32'(columns_q) > MAX_COLUMNS) ? COUNT_W'(MAX_COLUMNS) : columns_q;
	assign rows_eff = (32'(rows_q) > MAX_ROWS) ? COUNT_W'(MAX_ROWS) : rows_q;

	// One hundredth of a tile, rounded down.
	assign bo_prod = BOW'(unit) * BOW'(BO_MUL);

	// Operands of the axis in work.
	logic signed [COORD_W-1:0] a_from, a_to, a_other;
	logic [SIZE_W-1:0]         a_size, a_osize;
	logic                      a_neg;
	logic signed [DBL_W-1:0]   a_lead, a_pa, a_pb, to2, other2;

	assign a_from = axis_q ? sy_q : sx_q;
	assign a_to = axis_q ? gy_q : gx_q;
	assign a_other = axis_q ? sx_q : sy_q;
	assign a_size = axis_q ? bh_q : bw_q;
	assign a_osize = axis_q ? bw_q : bh_q;
	assign a_neg = a_to < a_from;
	assign to2 = {a_to[COORD_W-1], a_to, 1'b0};
	assign other2 = {a_other[COORD_W-1], a_other, 1'b0};
	assign a_lead = a_neg ? to2 - $signed(DBL_W'(a_size)) : to2 + $signed(DBL_W'(a_size));
	assign a_pa = other2 - $signed(DBL_W'(a_osize));
	assign a_pb = other2 + $signed(DBL_W'(a_osize));

	// Divider operand selection.
	logic                    div_start;
	logic signed [DBL_W-1:0] div_dvd;
	logic [DVS_W-1:0]        div_dvs;
	logic                    div_done;
	logic signed [DBL_W-1:0] div_quo;

	assign div_start = (state_q == ST_ISSUE);

	always_comb begin
		case (step_q)
			STEP_TILE: begin
				div_dvd = DBL_W'(a_from);
				div_dvs = DVS_W'(unit);
			end
			STEP_LEAD: begin
				div_dvd = a_lead;
				div_dvs = unit2;
			end
			STEP_PA: begin
				div_dvd = a_pa;
				div_dvs = unit2;
			end
			default: begin
				div_dvd = a_pb;
				div_dvs = unit2;
			end
		endcase
	end

	tmbc_div #(
		.DVS_W(DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.done(div_done),
		.quotient(div_quo)
	);

	// Map probe: the column comes from the lead, the row from probe A or B.
	logic signed [DBL_W-1:0] row_q_sel;
	logic                    probe_off;
	logic [IXW-1:0]          probe_idx;
	logic [AW-1:0]           rd_addr;
	logic                    rd_data;

	assign row_q_sel = (state_q == ST_RD_B) ? qb_q : qa_q;
	assign probe_off = ql_q[DBL_W-1] || row_q_sel[DBL_W-1]
		|| (ql_q[DBL_W-2:0] >= (DBL_W-1)'(cols_eff))
		|| (row_q_sel[DBL_W-2:0] >= (DBL_W-1)'(rows_eff));
	assign probe_idx = IXW'(row_q_sel[COUNT_W-1:0]) * IXW'(cols_eff)
		+ IXW'(ql_q[COUNT_W-1:0]);
	assign rd_addr = probe_idx[AW-1:0];

	// Tile map writes: the clearing pass after reset, then tile write items.
	logic           in_xfer;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic           ram_wdata;
	logic [TXW-1:0] tidx_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign tidx_ext = TXW'(tile_index);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q[AW-1:0];
			ram_wdata = 1'b0;
		end else begin
			ram_we = in_xfer && (operation == OP_WRITE) && (32'(tile_index) < DEPTH);
			ram_waddr = tidx_ext[AW-1:0];
			ram_wdata = tile_open;
		end
	end

	tmbc_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH),
		.AW(AW)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Clamp against the start tile edge, halved with a floor, then saturated.
	logic signed [FW-1:0] clamp2;
	logic signed [FW-1:0] clamp;
	logic signed [COORD_W-1:0] clamp_sat;

	assign clamp2 = a_neg
		? (FW'(prod_q) <<< 1) + $signed(FW'(a_size))
		: ((FW'(prod_q) - $signed(FW'(ud_q))) <<< 1) - $signed(FW'(a_size));
	assign clamp = clamp2 >>> 1;
	assign clamp_sat = (clamp > SAT_HI) ? COORD_W'(SAT_HI)
		: ((clamp < SAT_LO) ? COORD_W'(SAT_LO) : COORD_W'(clamp));

	// Axis outcome, taken when an axis finishes.
	logic                      axis_end;
	logic signed [COORD_W-1:0] axis_val;
	logic                      axis_hit;

	always_comb begin
		axis_end = 1'b0;
		axis_val = a_to;
		axis_hit = 1'b0;
		case (state_q)
			ST_NEXT: axis_end = (a_to == a_from);
			ST_CK_B: axis_end = rd_data;
			ST_FIX: begin
				axis_end = 1'b1;
				axis_val = clamp_sat;
				axis_hit = 1'b1;
			end
			default: axis_end = 1'b0;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= RST_COLUMNS;
			rows_q <= RST_ROWS;
			pixels_q <= RST_TILE_PIXELS;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_COLUMNS: columns_q <= cfg_data[COUNT_W-1:0];
				CFG_ROWS: rows_q <= cfg_data[COUNT_W-1:0];
				CFG_TILE_PIXELS: pixels_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q <= STEP_TILE;
			axis_q <= 1'b0;
			clr_q <= '0;
			ov_q <= 1'b0;
		end else begin
			// The result register fills from DONE and empties on an output transfer.
			if ((state_q == ST_DONE) && (!ov_q || out_ready)) begin
				ov_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW + 1)'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer && (operation == OP_QUERY)) begin
						axis_q <= 1'b0;
						step_q <= STEP_TILE;
						if ((start_x == goal_x) && (start_y == goal_y)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_ISSUE: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (step_q == STEP_PB) begin
							state_q <= ST_RD_A;
						end else begin
							step_q <= step_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_NEXT: begin
					if (!axis_end) begin
						step_q <= STEP_TILE;
						state_q <= ST_ISSUE;
					end
				end
				ST_RD_A: state_q <= probe_off ? ST_MUL : ST_CK_A;
				ST_CK_A: state_q <= rd_data ? ST_RD_B : ST_MUL;
				ST_RD_B: state_q <= probe_off ? ST_MUL : ST_CK_B;
				ST_CK_B: begin
					if (!rd_data) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_FIX;
				// The clamp always ends the axis; the hand-over below moves on.
				ST_FIX: ;
				ST_DONE: begin
					if (!ov_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// A finished axis hands over to the y axis or to the result.
			if (axis_end) begin
				if (!axis_q) begin
					axis_q <= 1'b1;
					state_q <= ST_NEXT;
				end else begin
					state_q <= ST_DONE;
				end
			end
		end
	end

	// Query operands, division results and the clamp product.
	always_ff @(posedge clk) begin
		if (in_xfer && (operation == OP_QUERY)) begin
			sx_q <= start_x;
			sy_q <= start_y;
			gx_q <= goal_x;
			gy_q <= goal_y;
			bw_q <= box_width;
			bh_q <= box_height;
			nx_q <= goal_x;
			ny_q <= goal_y;
			hx_q <= 1'b0;
			hy_q <= 1'b0;
			ud_q <= UW'(bo_prod[BOW-1:BO_SH]);
		end
		if ((state_q == ST_DIV) && div_done) begin
			case (step_q)
				STEP_TILE: t_q <= div_quo;
				STEP_LEAD: ql_q <= div_quo;
				STEP_PA: qa_q <= div_quo;
				default: qb_q <= div_quo;
			endcase
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'((a_neg ? (DBL_W + 1)'(t_q) : (DBL_W + 1)'(t_q) + (DBL_W + 1)'(1))
				* $signed({1'b0, unit}));
		end
		if (axis_end) begin
			if (!axis_q) begin
				nx_q <= axis_val;
				hx_q <= axis_hit;
			end else begin
				ny_q <= axis_val;
				hy_q <= axis_hit;
			end
		end
	end

	// Result register.
	logic signed [COORD_W-1:0] rx_q, ry_q;
	logic                      rhx_q, rhy_q;

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!ov_q || out_ready)) begin
			rx_q <= nx_q;
			ry_q <= ny_q;
			rhx_q <= hx_q;
			rhy_q <= hy_q;
		end
	end

	assign out_valid = ov_q;
	assign new_x = rx_q;
	assign new_y = ry_q;
	assign hit_x = rhx_q;
	assign hit_y = rhy_q;

endmodule
`default_nettype wire

### hw/rtl/tmbc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module tmbc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/tmbc_div.sv
// Shared iterative divider: signed dividend by unsigned divisor, quotient
// truncated toward zero, one quotient bit per cycle. Depends on tmbc_pkg.
`default_nettype none
module tmbc_div import tmbc_pkg::*; #(
	parameter int DVS_W = 18
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [DBL_W-1:0] dividend,
	input  wire logic        [DVS_W-1:0] divisor,
	output logic                         done,
	output logic signed      [DBL_W-1:0] quotient
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [MAG_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [MAG_W-1:0] mag;
	logic [DVS_W+1:0] trial;

	assign mag = dividend[DBL_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
	assign trial = {1'b0, rem_q, quo_q[MAG_W-1]} - {2'b00, dvs_q};

	// Control: a start loads the operands, then one step per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring shift-subtract datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= mag;
			neg_q <= dividend[DBL_W-1];
		end else if (busy_q) begin
			if (!trial[DVS_W+1]) begin
				rem_q <= trial[DVS_W-1:0];
			end else begin
				rem_q <= {rem_q[DVS_W-2:0], quo_q[MAG_W-1]};
			end
			quo_q <= {quo_q[MAG_W-2:0], ~trial[DVS_W+1]};
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule
`default_nettype wire

### test/tb_tile_map_box_collision_top.sv
// Testbench for tile_map_box_collision_top: tile writes and box queries against a built-in predictor.
// Depends on tmbc_pkg and the block; a queue-fed driver and a clocked monitor check every result.
`timescale 1ns / 100ps
`default_nettype none
module tb_tile_map_box_collision_top;
	import tmbc_pkg::*;

	localparam int MAP_DEPTH = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic                      op;
		logic [TIDX_W-1:0]         tidx;
		logic                      topen;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] gx;
		logic signed [COORD_W-1:0] gy;
		logic [SIZE_W-1:0]         bw;
		logic [SIZE_W-1:0]         bh;
	} move_item_t;

	typedef struct {
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic                      hx;
		logic                      hy;
	} move_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic [TIDX_W-1:0] tile_index;
	logic tile_open;
	logic signed [COORD_W-1:0] start_x, start_y, goal_x, goal_y;
	logic [SIZE_W-1:0] box_width, box_height;
	logic out_valid;
	logic out_ready;
	logic signed [COORD_W-1:0] new_x, new_y;
	logic hit_x, hit_y;

	tile_map_box_collision_top i_dut (.*);

	// Predictor state: tile map and register copies.
	logic tile_map [MAP_DEPTH];
	logic [COUNT_W-1:0] map_cols;
	logic [COUNT_W-1:0] map_rows;
	logic [PIX_W-1:0] tile_pix;

	move_item_t pending_items[$];
	move_result_t expected_moves[$];
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	int offered_cnt;
	int accepted_cnt;
	int error_cnt;
	longint cycle_cnt;

	function automatic longint unit_size();
		return longint'(tile_pix == 0 ? 1 : tile_pix) <<< DEF_FRACTION_BITS;
	endfunction

	function automatic longint cols_used();
		return map_cols > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS : longint'(map_cols);
	endfunction

	function automatic longint rows_used();
		return map_rows > DEF_MAX_ROWS ? DEF_MAX_ROWS : longint'(map_rows);
	endfunction

	// Passability of a point given at doubled precision; off-map is blocked.
	function automatic logic tile_passable(longint x2, longint y2);
		longint u2, tx, ty;
		u2 = 2 * unit_size();
		tx = x2 / u2;
		ty = y2 / u2;
		if (tx < 0 || ty < 0 || tx >= cols_used() || ty >= rows_used())
			return 1'b0;
		return tile_map[ty * cols_used() + tx];
	endfunction

	// One axis of the move: probe both leading corners, clamp on a hit.
	function automatic longint clamp_axis(longint from, longint to, longint size,
			longint other, longint other_size, output logic hit);
		longint u, t, lead, d, hi, lo;
		u = unit_size();
		t = from / u;
		hit = 1'b0;
		if (to == from)
			return to;
		lead = (to < from) ? 2 * to - size : 2 * to + size;
		if (tile_passable(lead, 2 * other - other_size) &&
				tile_passable(lead, 2 * other + other_size))
			return to;
		hit = 1'b1;
		if (to < from)
			d = 2 * t * u + size;
		else
			d = 2 * ((t + 1) * u - u / BACKOFF_DIV) - size;
		d = (d - (d & 1)) / 2;
		hi = (longint'(1) <<< (COORD_W - 1)) - 1;
		lo = -hi - 1;
		return d > hi ? hi : (d < lo ? lo : d);
	endfunction

	function automatic move_result_t predict_move(move_item_t it);
		move_result_t r;
		longint sx, sy, gx, gy;
		logic hx, hy;
		sx = it.sx;
		sy = it.sy;
		gx = it.gx;
		gy = it.gy;
		hx = 1'b0;
		hy = 1'b0;
		if (sx == gx && sy == gy) begin
			r.nx = it.gx;
			r.ny = it.gy;
		end else begin
			r.nx = COORD_W'(clamp_axis(sx, gx, it.bw, sy, it.bh, hx));
			r.ny = COORD_W'(clamp_axis(sy, gy, it.bh, sx, it.bw, hy));
		end
		r.hx = hx;
		r.hy = hy;
		return r;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Driver: presents queued items, idling at random between transfers.
	always @(negedge clk) begin
		move_item_t it;
		if (arst_n && !(in_valid && accepted_cnt != offered_cnt)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				operation <= it.op;
				tile_index <= it.tidx;
				tile_open <= it.topen;
				start_x <= it.sx;
				start_y <= it.sy;
				goal_x <= it.gx;
				goal_y <= it.gy;
				box_width <= it.bw;
				box_height <= it.bh;
				in_valid <= 1'b1;
				offered_cnt++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: checks result transfers, predicts on input transfers, bounds the run.
	always @(posedge clk) begin
		move_item_t it;
		move_result_t exp_r;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t timeout", $realtime);
			$display("== FAIL ==");
			$finish;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_moves.size() == 0) begin
					$display("%0t unexpected result x=%0d y=%0d", $realtime, new_x, new_y);
					error_cnt++;
				end else begin
					exp_r = expected_moves.pop_front();
					if (new_x !== exp_r.nx || new_y !== exp_r.ny ||
							hit_x !== exp_r.hx || hit_y !== exp_r.hy) begin
						$display("%0t mismatch: expected x=%0d y=%0d hx=%0b hy=%0b, got x=%0d y=%0d hx=%0b hy=%0b",
							$realtime, exp_r.nx, exp_r.ny, exp_r.hx, exp_r.hy,
							new_x, new_y, hit_x, hit_y);
						error_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				it.op = operation;
				it.tidx = tile_index;
				it.topen = tile_open;
				it.sx = start_x;
				it.sy = start_y;
				it.gx = goal_x;
				it.gy = goal_y;
				it.bw = box_width;
				it.bh = box_height;
				if (it.op == OP_WRITE) begin
					if (it.tidx < MAP_DEPTH)
						tile_map[it.tidx] = it.topen;
				end else begin
					expected_moves.push_back(predict_move(it));
				end
				accepted_cnt++;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_COLUMNS: map_cols = value[COUNT_W-1:0];
			CFG_ROWS: map_rows = value[COUNT_W-1:0];
			CFG_TILE_PIXELS: tile_pix = value;
			default: ;
		endcase
	endtask

	task automatic set_map(int cols, int rows, int pix);
		write_reg(CFG_COLUMNS, CFG_DATA_W'(cols));
		write_reg(CFG_ROWS, CFG_DATA_W'(rows));
		write_reg(CFG_TILE_PIXELS, CFG_DATA_W'(pix));
	endtask

	task automatic wait_drained();
		wait (pending_items.size() == 0 && accepted_cnt == offered_cnt &&
			expected_moves.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_write(int idx, logic open_bit);
		move_item_t it;
		it = '{default: '0};
		it.op = OP_WRITE;
		it.tidx = TIDX_W'(idx);
		it.topen = open_bit;
		it.sx = COORD_W'($urandom);
		it.gy = COORD_W'($urandom);
		pending_items.push_back(it);
	endtask

	task automatic add_query(longint sx, longint sy, longint gx, longint gy,
			longint bw, longint bh);
		move_item_t it;
		it.op = OP_QUERY;
		it.tidx = TIDX_W'($urandom);
		it.topen = 1'($urandom);
		it.sx = COORD_W'(sx);
		it.sy = COORD_W'(sy);
		it.gx = COORD_W'(gx);
		it.gy = COORD_W'(gy);
		it.bw = SIZE_W'(bw);
		it.bh = SIZE_W'(bh);
		pending_items.push_back(it);
	endtask

	function automatic longint pick(longint lo, longint hi);
		return lo + longint'($urandom_range(int'(hi - lo)));
	endfunction

	// Random traffic shaped by the current map: mostly in-map moves near walls.
	task automatic add_random(int count);
		longint u, sx, sy, gx, gy, bw, bh, spanx, spany;
		int ntiles, roll;
		u = unit_size();
		spanx = cols_used() * u;
		spany = rows_used() * u;
		ntiles = int'(cols_used() * rows_used());
		for (int i = 0; i < count; i++) begin
			roll = int'($urandom_range(99));
			if (roll < 30) begin
				if (ntiles > 0 && roll < 27)
					add_write(int'($urandom_range(ntiles - 1)), $urandom_range(99) < 70);
				else
					add_write(int'($urandom), 1'($urandom));
			end else if (roll < 35) begin
				add_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				sx = pick(-u / 2, spanx + u / 2);
				sy = pick(-u / 2, spany + u / 2);
				gx = sx + pick(-2 * u, 2 * u);
				gy = sy + pick(-2 * u, 2 * u);
				bw = pick(0, u * 3 / 2 > 65535 ? 65535 : u * 3 / 2);
				bh = pick(0, u * 3 / 2 > 65535 ? 65535 : u * 3 / 2);
				if (roll < 45) begin
					gx = sx;
					gy = sy;
				end else if (roll < 55) begin
					gx = sx;
				end else if (roll < 65) begin
					gy = sy;
				end
				add_query(sx, sy, gx, gy, bw, bh);
			end
		end
	endtask

	task automatic run_phase(int idle, int stall, int count);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		add_random(count);
		wait_drained();
	endtask

	// Stimulus sequence.
	initial begin
		for (int i = 0; i < MAP_DEPTH; i++)
			tile_map[i] = 1'b0;
		map_cols = RST_COLUMNS;
		map_rows = RST_ROWS;
		tile_pix = RST_TILE_PIXELS;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		operation = OP_WRITE;
		tile_index = '0;
		tile_open = 1'b0;
		start_x = '0;
		start_y = '0;
		goal_x = '0;
		goal_y = '0;
		box_width = '0;
		box_height = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		offered_cnt = 0;
		accepted_cnt = 0;
		error_cnt = 0;
		cycle_cnt = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part on a 4x4 map of 16-pixel tiles (one tile is 4096 LSB).
		set_map(4, 4, 16);
		write_reg(CFG_UNUSED, 9'h1FF);
		add_write(5, 1'b1);
		add_write(6, 1'b1);
		add_write(9, 1'b1);
		add_write(4095, 1'b0);
		// Start equals goal, with extreme coordinates and sizes.
		add_query(-16777216, 16777215, -16777216, 16777215, 65535, 0);
		// Open moves from tile 5 into tiles 6 and 9, then moves into blocked tiles along -x, -y and +y.
		add_query(6144, 6144, 10240, 6144, 1024, 1024);
		add_query(10240, 6144, 2048, 6144, 1024, 1024);
		add_query(6144, 6144, 6144, 10240, 1024, 1024);
		add_query(6144, 6144, 6144, 2048, 1024, 1024);
		add_query(6144, 10240, 6144, 14000, 0, 0);
		// Moves whose probes fall off the map on the negative and the positive side.
		add_query(-100, -100, -9000, -50, 512, 512);
		add_query(6144, 6144, 20000, 20000, 65535, 65535);
		add_query(16777215, 16777215, -16777216, -16777216, 65535, 65535);
		add_query(-16777216, -16777216, 16777215, 16777215, 0, 65535);
		wait_drained();

		// 256-pixel tiles on the largest map, with moves near the ends of the coordinate range.
		set_map(64, 64, 256);
		add_write(4095, 1'b1);
		add_query(16777215, 16777215, 16777000, 16777215, 65535, 65535);
		add_query(16777215, -16777216, 16777215, -16777000, 65535, 65535);
		add_query(-16777216, 16777215, -16777000, 16777215, 65535, 65535);
		wait_drained();

		set_map(8, 6, 16);
		run_phase(0, 0, 190);

		// Long receiver hold-off while the sender keeps offering items.
		set_map(5, 7, 4);
		hold_request = 3000;
		run_phase(0, 0, 60);

		set_map(1, 1, 1);
		run_phase(66, 0, 60);

		// Sender pause mid-phase until every result is back.
		set_map(16, 16, 32);
		send_idle_pct = 0;
		recv_stall_pct = 66;
		add_random(40);
		wait_drained();
		add_random(40);
		wait_drained();

		set_map(0, 3, 0);
		run_phase(23, 23, 40);

		set_map(127, 100, 511);
		run_phase(23, 23, 60);

		set_map(64, 64, 2);
		run_phase(66, 66, 70);

		set_map(3, 64, 8);
		run_phase(0, 66, 70);

		if (error_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
